// ----- sv/ufss_pkg.sv -----
// ufss_pkg: shared types and constants for the union-find engine.
// Used by ufss_ctrl, ufss_dp and union_find_with_set_sizes. No dependencies.
package ufss_pkg;

  localparam int NODE_W = 12;   // width of a node field on the ports
  localparam int SIZE_W = 13;   // width of a set size (up to 4096)
  localparam int RECIP_SH = 24; // shift of the reciprocal used for index reduction

  // datapath operation, one per cycle
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_CLEAR = 4'd1,
    OP_LOAD  = 4'd2,
    OP_RED   = 4'd3,
    OP_READ  = 4'd4,
    OP_WALK  = 4'd5,
    OP_FOUND = 4'd6,
    OP_COMP  = 4'd7,
    OP_SZ1   = 4'd8,
    OP_SZ2   = 4'd9,
    OP_SZ3   = 4'd10,
    OP_OUT   = 4'd11
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   side;   // 0: x operand, 1: y operand
  } cmd_t;

  typedef struct packed {
    logic clr_done;   // last entry of the clearing pass is being written
    logic is_root;    // parent read back equals the walked node
    logic comp_done;  // compression walk has reached the root
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ----- sv/ufss_ctrl.sv -----
// ufss_ctrl: sequencer for the union-find engine.
// Depends on ufss_pkg; drives ufss_dp through cmd_t and reads status_t.
module ufss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ufss_pkg::status_t st,
  output ufss_pkg::cmd_t    cmd
);
  import ufss_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_RED   = 10'b00_0000_0100,
    S_READ  = 10'b00_0000_1000,
    S_WALK  = 10'b00_0001_0000,
    S_COMP  = 10'b00_0010_0000,
    S_SZ1   = 10'b00_0100_0000,
    S_SZ2   = 10'b00_1000_0000,
    S_SZ3   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   side, side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd.op     = OP_NOP;
    cmd.side   = side;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.op     = OP_RED;
        side_next  = 1'b0;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.op     = OP_READ;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (st.is_root) begin
          cmd.op     = OP_FOUND;
          state_next = S_COMP;
        end else begin
          cmd.op = OP_WALK;
        end
      end
      S_COMP: begin
        if (st.comp_done) begin
          if (!side) begin
            side_next  = 1'b1;
            state_next = S_READ;
          end else begin
            state_next = S_SZ1;
          end
        end else begin
          cmd.op = OP_COMP;
        end
      end
      S_SZ1: begin
        cmd.op     = OP_SZ1;
        state_next = S_SZ2;
      end
      S_SZ2: begin
        cmd.op     = OP_SZ2;
        state_next = S_SZ3;
      end
      S_SZ3: begin
        cmd.op     = OP_SZ3;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // no beat taken in the first cycle after reset: the clearing pass runs first
  a_ready_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready) else $error("input ready right after reset");

  // one request at a time: ready drops after an accepted beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("ready held after accept");

endmodule

// ----- sv/ufss_dp.sv -----
// ufss_dp: datapath of the union-find engine: parent and size memories,
// index reduction, walk registers and the output register. Depends on ufss_pkg.
module ufss_dp #(
  parameter int NODES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ufss_pkg::cmd_t              cmd,
  output ufss_pkg::status_t           st,
  input  logic                        in_action,
  input  logic [ufss_pkg::NODE_W-1:0] in_node_a,
  input  logic [ufss_pkg::NODE_W-1:0] in_node_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ufss_pkg::NODE_W-1:0] out_root_a,
  output logic [ufss_pkg::NODE_W-1:0] out_root_b,
  output logic                        out_joined,
  output logic [ufss_pkg::SIZE_W-1:0] out_size
);
  import ufss_pkg::*;

  localparam int IW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int RW    = (IW > NODE_W) ? IW : NODE_W;
  localparam int SPAN  = 1 << NODE_W;
  // only nodes below min(NODES, 2^NODE_W) are ever touched
  localparam int CLR_N = (NODES < SPAN) ? NODES : SPAN;
  localparam int QW    = NODE_W + RECIP_SH;
  // x mod NODES = x - floor(x*RECIP >> 24)*NODES, exact for 12-bit x, NODES < 4096
  localparam logic [RECIP_SH-1:0] RECIP =
    (NODES >= SPAN) ? '0 : RECIP_SH'(((1 << RECIP_SH) + NODES - 1) / NODES);
  localparam logic [NODE_W-1:0] NMUL = (NODES >= SPAN) ? '0 : NODE_W'(NODES);

  // memories
  logic [IW-1:0]     pmem [NODES];
  logic [SIZE_W-1:0] smem [NODES];

  logic              p_we;
  logic [IW-1:0]     p_waddr, p_wdata, p_raddr, p_rdata;
  logic              s_we;
  logic [IW-1:0]     s_waddr, s_raddr;
  logic [SIZE_W-1:0] s_wdata, s_rdata;

  // request and walk registers
  logic [NODE_W-1:0] raw_a, raw_b, q_a, q_b;
  logic              merge;
  logic [IW-1:0]     x, y, cur, root_a, root_b, cnt;
  logic [SIZE_W-1:0] sz_a, res_size;

  logic [QW-1:0]       qa_full, qb_full;
  logic [2*NODE_W-1:0] pa, pb;
  logic [NODE_W-1:0]   ra12, rb12;
  logic [RW-1:0]       ra_ext, rb_ext, oa_ext, ob_ext;
  logic [IW-1:0]       start, root_sel;
  logic                joined, do_merge;
  logic [SIZE_W-1:0]   sum;

  assign qa_full = QW'(in_node_a) * QW'(RECIP);
  assign qb_full = QW'(in_node_b) * QW'(RECIP);
  assign pa      = (2*NODE_W)'(q_a) * (2*NODE_W)'(NMUL);
  assign pb      = (2*NODE_W)'(q_b) * (2*NODE_W)'(NMUL);
  assign ra12    = raw_a - pa[NODE_W-1:0];
  assign rb12    = raw_b - pb[NODE_W-1:0];
  assign ra_ext  = RW'(ra12);
  assign rb_ext  = RW'(rb12);

  assign start    = cmd.side ? y : x;
  assign root_sel = cmd.side ? root_b : root_a;
  assign joined   = (root_a == root_b);
  assign do_merge = merge && !joined;
  assign sum      = sz_a + s_rdata;

  assign st.clr_done  = (cnt == IW'(CLR_N - 1));
  assign st.is_root   = (p_rdata == cur);
  assign st.comp_done = (cur == root_sel);
  assign st.out_free  = !out_valid || out_ready;

  // memory port control
  always_comb begin
    p_we    = 1'b0;
    p_waddr = cur;
    p_wdata = root_sel;
    p_raddr = cur;
    s_we    = 1'b0;
    s_waddr = root_a;
    s_wdata = '0;
    s_raddr = root_a;
    case (cmd.op)
      OP_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = cnt;
        p_wdata = cnt;
        s_we    = 1'b1;
        s_waddr = cnt;
        s_wdata = SIZE_W'(1);
      end
      OP_READ:  p_raddr = start;
      OP_WALK:  p_raddr = p_rdata;
      OP_FOUND: p_raddr = start;
      OP_COMP: begin
        p_we    = 1'b1;
        p_raddr = p_rdata;
      end
      OP_SZ1: s_raddr = root_a;
      OP_SZ2: begin
        s_raddr = root_b;
        s_we    = do_merge;   // absorbed root loses its count
      end
      OP_SZ3: begin
        p_we    = do_merge;   // attach x's root under y's root
        p_waddr = root_a;
        p_wdata = root_b;
        s_we    = do_merge;
        s_waddr = root_b;
        s_wdata = sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    s_rdata <= smem[s_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) cnt <= cnt + 1'b1;
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        raw_a <= in_node_a;
        raw_b <= in_node_b;
        merge <= in_action;
        q_a   <= qa_full[QW-1:RECIP_SH];
        q_b   <= qb_full[QW-1:RECIP_SH];
      end
      OP_RED: begin
        x <= ra_ext[IW-1:0];
        y <= rb_ext[IW-1:0];
      end
      OP_READ: cur <= start;
      OP_WALK: cur <= p_rdata;
      OP_FOUND: begin
        if (cmd.side) root_b <= cur;
        else root_a <= cur;
        cur <= start;
      end
      OP_COMP: cur <= p_rdata;
      OP_SZ2:  sz_a <= s_rdata;
      OP_SZ3:  res_size <= do_merge ? sum : sz_a;
      default: begin
      end
    endcase
  end

  assign oa_ext = RW'(root_a);
  assign ob_ext = RW'(root_b);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_root_a <= oa_ext[NODE_W-1:0];
      out_root_b <= ob_ext[NODE_W-1:0];
      out_joined <= joined;
      out_size   <= res_size;
    end
  end

  // a result is only loaded when the output register is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken beat");

  // outside the clearing pass no link ever points a node at itself
  a_no_self_link: assert property (@(posedge clk) disable iff (rst)
    (p_we && cmd.op != OP_CLEAR) |-> (p_waddr != p_wdata))
    else $error("parent write makes a new root");

  // both roots of a merge carry a nonzero count
  a_root_sizes: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SZ3 && do_merge) |-> (sz_a != '0 && s_rdata != '0))
    else $error("merge of a root with zero size");

endmodule

// ----- sv/union_find_with_set_sizes.sv -----
// union_find_with_set_sizes: top level of the disjoint-set engine.
// Depends on ufss_pkg, ufss_ctrl (sequencer) and ufss_dp (memories, datapath).
//
//  channel  | dir | tdata / tuser
//  ---------+-----+---------------------------------------------------------
//  s_*      | in  | tuser: action; tdata: node_a, node_b
//  m_*      | out | tdata: root_a, root_b, already_joined, set_size
//
// Walk: a request follows the parent links from node_a to its root and
//   compresses that path, then does the same for node_b; each hop is one
//   read of the parent memory on the way up and one read plus write on the
//   compression pass. Path compression keeps the hop counts small.
// Reset: a clearing pass writes every reachable entry, the first min(NODES, 4096)
//   (parent = own index, size = 1); s_tready stays low meanwhile.
// Stalls: the result sits in an output register; the next request can be
//   taken while that beat waits, and only the final load waits for m_tready.
module union_find_with_set_sizes #(
  parameter int NODES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // [0] action (1 = merge)
  input  logic [23:0] s_tdata,   // [11:0] node_a, [23:12] node_b
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [11:0] root_a, [23:12] root_b, [24] already_joined,
                                 // [37:25] set_size, [39:38] zero
);
  import ufss_pkg::*;

  cmd_t    cmd;
  status_t st;

  logic [NODE_W-1:0] root_a, root_b;
  logic              joined;
  logic [SIZE_W-1:0] set_size;

  ufss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ufss_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_action  (s_tuser),
    .in_node_a  (s_tdata[11:0]),
    .in_node_b  (s_tdata[23:12]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_root_a (root_a),
    .out_root_b (root_b),
    .out_joined (joined),
    .out_size   (set_size)
  );

  // pack result beat, first field lowest
  assign m_tdata = {2'b00, set_size, joined, root_b, root_a};

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for the union_find_with_set_sizes engine.
// Drives query/merge requests on the s_* stream, keeps its own disjoint-set
// shadow to predict each m_* beat, and compares field by field. Needs ufss_pkg.
module tb_top;
  import ufss_pkg::*;

  localparam int NODE_CNT = 4096;
  localparam int RANDOM_REQS = 2000;
  localparam int DRAIN_CYCLES = 200;  // wait after the last result, before the verdict
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_MERGE = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SIZE_W-1:0] count_t;

  typedef struct packed {
    node_t  root_a;
    node_t  root_b;
    logic   joined;
    count_t set_size;
  } uf_result_t;

  // typed = 1: res is the hand-derived answer, used instead of the shadow's
  typedef struct packed {
    logic       typed;
    uf_result_t res;
  } req_note_t;

  typedef struct packed {
    logic       action;
    node_t      node_a;
    node_t      node_b;
    logic       typed;
    uf_result_t res;
  } dir_row_t;

  typedef enum logic [1:0] {MIX_CHAIN, MIX_LOCAL, MIX_WIDE} mix_t;

  localparam uf_result_t NO_RES = '0;

  // Directed part: corner indices, joined merges, a chain to walk and compress.
  localparam dir_row_t DIR_ROWS [20] = '{
    '{ACT_QUERY, 12'd0,    12'd0,    1'b1, '{12'd0,    12'd0,    1'b1, 13'd1}},
    '{ACT_QUERY, 12'd4095, 12'd0,    1'b1, '{12'd4095, 12'd0,    1'b0, 13'd1}},
    '{ACT_MERGE, 12'd4095, 12'd0,    1'b1, '{12'd4095, 12'd0,    1'b0, 13'd2}},
    // merge on an already joined pair leaves everything alone
    '{ACT_MERGE, 12'd0,    12'd4095, 1'b1, '{12'd0,    12'd0,    1'b1, 13'd2}},
    '{ACT_QUERY, 12'd4095, 12'd4095, 1'b1, '{12'd0,    12'd0,    1'b1, 13'd2}},
    '{ACT_MERGE, 12'hAAA,  12'h555,  1'b1, '{12'hAAA,  12'h555,  1'b0, 13'd2}},
    '{ACT_MERGE, 12'h555,  12'hAAA,  1'b1, '{12'h555,  12'h555,  1'b1, 13'd2}},
    '{ACT_QUERY, 12'hAAA,  12'd0,    1'b1, '{12'h555,  12'd0,    1'b0, 13'd2}},
    '{ACT_MERGE, 12'd1,    12'd2,    1'b1, '{12'd1,    12'd2,    1'b0, 13'd2}},
    '{ACT_MERGE, 12'd2,    12'd3,    1'b1, '{12'd2,    12'd3,    1'b0, 13'd3}},
    '{ACT_MERGE, 12'd3,    12'd4,    1'b1, '{12'd3,    12'd4,    1'b0, 13'd4}},
    '{ACT_MERGE, 12'd4,    12'd5,    1'b1, '{12'd4,    12'd5,    1'b0, 13'd5}},
    // 1 -> 2 -> 3 -> 4 -> 5: long walk, then the compressed path
    '{ACT_QUERY, 12'd1,    12'd5,    1'b0, NO_RES},
    '{ACT_QUERY, 12'd1,    12'd1,    1'b0, NO_RES},
    '{ACT_MERGE, 12'hAAA,  12'd1,    1'b0, NO_RES},
    '{ACT_MERGE, 12'd5,    12'd4095, 1'b0, NO_RES},
    '{ACT_QUERY, 12'hAAA,  12'd0,    1'b0, NO_RES},
    '{ACT_MERGE, 12'h800,  12'h7FF,  1'b0, NO_RES},
    '{ACT_QUERY, 12'h7FF,  12'h800,  1'b0, NO_RES},
    '{ACT_MERGE, 12'h7FF,  12'hAAA,  1'b0, NO_RES}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic        s_tuser;   // [0] action
  logic [23:0] s_tdata;   // [11:0] node_a, [23:12] node_b
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [11:0] root_a, [23:12] root_b, [24] joined, [37:25] set_size

  // shadow forest
  node_t      parent_q [NODE_CNT];
  count_t     size_q [NODE_CNT];
  uf_result_t pending_results [$];
  req_note_t  req_notes [$];
  bit         failed = 1'b0;
  bit         src_calm = 1'b0;
  bit         sink_calm = 1'b0;

  union_find_with_set_sizes dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // Root lookup with full path compression on the shadow forest.
  function automatic node_t root_with_compress(node_t n);
    node_t r;
    node_t cur;
    node_t nxt;
    r = n;
    while (parent_q[r] != r) r = parent_q[r];
    cur = n;
    while (cur != r) begin
      nxt = parent_q[cur];
      parent_q[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  // x's root goes under y's root; sizes live only at roots.
  function automatic uf_result_t apply_request(logic action, node_t a, node_t b);
    uf_result_t res;
    res.root_a = root_with_compress(a);
    res.root_b = root_with_compress(b);
    res.joined = (res.root_a == res.root_b);
    if (action == ACT_MERGE && !res.joined) begin
      size_q[res.root_b] = size_q[res.root_b] + size_q[res.root_a];
      size_q[res.root_a] = '0;
      parent_q[res.root_a] = res.root_b;
      res.set_size = size_q[res.root_b];
    end else begin
      res.set_size = size_q[res.root_a];
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // One request beat; valid stays up across back-to-back beats.
  task automatic send_request(logic action, node_t a, node_t b, logic typed,
                              uf_result_t res);
    int unsigned gap;
    req_note_t   note;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.res = res;
    req_notes.push_back(note);
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Monitor: check leaving beats first, then predict the one taken in.
  always @(posedge clk) begin
    uf_result_t got;
    uf_result_t want;
    uf_result_t model;
    req_note_t  note;
    if (!rst && m_tvalid && m_tready) begin
      got.root_a   = m_tdata[11:0];
      got.root_b   = m_tdata[23:12];
      got.joined   = m_tdata[24];
      got.set_size = m_tdata[37:25];
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("root_a", want.root_a, got.root_a);
        check_field("root_b", want.root_b, got.root_b);
        check_field("already_joined", want.joined, got.joined);
        check_field("set_size", want.set_size, got.set_size);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      note = req_notes.pop_front();
      model = apply_request(s_tuser, s_tdata[11:0], s_tdata[23:12]);
      pending_results.push_back(note.typed ? note.res : model);
    end
  end

  // Result sink with random back-pressure.
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    mix_t  mix;
    int    run_left;
    node_t base;
    node_t span;
    node_t cursor;
    node_t a;
    node_t b;
    logic  act;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = ACT_QUERY;
    s_tdata  = '0;
    run_left = 0;
    mix      = MIX_WIDE;
    base     = '0;
    span     = '0;
    cursor   = '0;
    for (int i = 0; i < NODE_CNT; i++) begin
      parent_q[i] = node_t'(i);
      size_q[i]   = count_t'(1);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_request(DIR_ROWS[i].action, DIR_ROWS[i].node_a, DIR_ROWS[i].node_b,
                   DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // Random part in runs: chains to build deep trees, dense merges in a small
    // window to grow sets, and scattered noise over the whole index range.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (run_left == 0) begin
        mix      = mix_t'($urandom_range(0, 2));
        run_left = $urandom_range(10, 40);
        base     = node_t'($urandom);
        cursor   = base;
        span     = $urandom_range(0, 1) ? node_t'(15) : node_t'(255);
      end
      run_left--;
      case (mix)
        MIX_CHAIN: begin
          if ($urandom_range(0, 3) == 0) begin
            act = ACT_QUERY;
            a   = base;
            b   = cursor;
          end else begin
            act    = ACT_MERGE;
            a      = cursor;
            b      = cursor + 1'b1;
            cursor = cursor + 1'b1;
          end
        end
        MIX_LOCAL: begin
          act = ($urandom_range(0, 9) < 6) ? ACT_MERGE : ACT_QUERY;
          a   = base + (node_t'($urandom) & span);
          b   = base + (node_t'($urandom) & span);
        end
        default: begin
          act = $urandom_range(0, 1) ? ACT_MERGE : ACT_QUERY;
          a   = node_t'($urandom);
          b   = node_t'($urandom);
        end
      endcase
      send_request(act, a, b, 1'b0, NO_RES);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
